>>> hw/rtl/ivalloc_pkg.sv
package ivalloc_pkg;

    // Default geometry of the vector tables.
    localparam int IVA_VECTORS      = 256;
    localparam int IVA_FIRST_VECTOR = 32;
    localparam int IVA_CPUS         = 4;

    // Legacy PIC window in which a hint may take a reserved but unused slot.
    localparam int PIC_LOW_VECTOR  = 32;
    localparam int PIC_HIGH_VECTOR = 47;

    // Reset value of the PIC mode register.
    localparam logic PIC_MODE_RESET = 1'b1;

    // One memory row holds the marks of eight consecutive vectors.
    localparam int SLOTS  = 8;
    localparam int SLOT_W = 3;

    // Field widths.
    localparam int OP_W    = 3;
    localparam int CPU_W   = 2;
    localparam int HINT_W  = 9;
    localparam int COUNT_W = 9;
    localparam int VEC_W   = 8;
    localparam int ST_W    = 2;
    localparam int LG_W    = 4;
    localparam int SPAN_W  = 10;

    typedef enum logic [OP_W-1:0] {
        OP_RESERVE_ONE   = 3'd0,
        OP_RESERVE_BLOCK = 3'd1,
        OP_FREE          = 3'd2,
        OP_ATTACH        = 3'd3,
        OP_DETACH        = 3'd4
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_NOSPACE = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_MODIFY,
        S_ONE,
        S_SMALL,
        S_BIG,
        S_MARK,
        S_FINISH
    } t_state;

    // Evaluation of one row of marks.
    typedef struct packed {
        logic              one_hit;
        logic [SLOT_W-1:0] one_idx;
        logic              grp_hit;
        logic [SLOT_W-1:0] grp_idx;
        logic [SLOTS-1:0]  grp_mask;
        logic              row_free;
    } t_row_eval;

endpackage

>>> hw/rtl/interrupt_vector_allocator.sv
// Channel   Direction  Handshake                  Payload
// request   in         i_in_valid / o_in_stall    i_operation i_cpu i_hint i_count i_vector
// result    out        o_out_valid / i_out_stall  o_result_vector o_status
// config    in         i_cfg_we                   i_cfg_wdata (pic mode)
//
// One request is worked at a time. Free, attach and detach of a device vector pass through
// decode, a read-modify-write state and the finish state; rejected requests and vectors outside
// the device range go from decode straight to finish. A reserve reads one mark row at a time (eight
// vectors a row), and a block of more than eight vectors then writes each row it marks in turn.
// The next request is accepted once the result is loaded; a held result delays that.
// After reset a clearing pass writes every memory row once while requests stall.
module interrupt_vector_allocator
    import ivalloc_pkg::*;
#(
    parameter int VECTORS      = IVA_VECTORS,
    parameter int FIRST_VECTOR = IVA_FIRST_VECTOR,
    parameter int CPUS         = IVA_CPUS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [OP_W-1:0]    i_operation,
    input  logic [CPU_W-1:0]   i_cpu,
    input  logic [HINT_W-1:0]  i_hint,
    input  logic [COUNT_W-1:0] i_count,
    input  logic [VEC_W-1:0]   i_vector,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [VEC_W-1:0]   o_result_vector,
    output logic [ST_W-1:0]    o_status
);

    localparam int ROWS      = (VECTORS + SLOTS - 1) / SLOTS;
    localparam int RW        = $clog2(ROWS);
    localparam int CW        = (CPUS > 1) ? $clog2(CPUS) : 1;
    localparam int DEPTH     = CPUS * (2 ** RW);
    localparam int AW        = $clog2(DEPTH);
    localparam int FIRST_ROW = FIRST_VECTOR / SLOTS;

    // Mark memory: used bits in the upper half of a row, reserved bits in the lower.
    logic [2*SLOTS-1:0] r_marks [DEPTH];
    logic [2*SLOTS-1:0] r_rdata;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [2*SLOTS-1:0] mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_clr, n_clr;
    logic                r_pic;
    logic [OP_W-1:0]     r_op, n_op;
    logic [CPU_W-1:0]    r_cpu, n_cpu;
    logic [HINT_W-1:0]   r_hint, n_hint;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [VEC_W-1:0]    r_vec, n_vec;
    logic [LG_W-1:0]     r_lg, n_lg;
    logic [RW-1:0]       r_row, n_row;
    logic [RW-1:0]       r_k, n_k;
    logic                r_first, n_first;
    logic [SPAN_W-1:0]   r_base, n_base;
    logic [VEC_W-1:0]    r_res_vec, n_res_vec;
    t_status             r_res_st, n_res_st;
    logic                r_out_valid, n_out_valid;
    logic [VEC_W-1:0]    r_out_vec, n_out_vec;
    t_status             r_out_st, n_out_st;

    logic [LG_W-1:0]     count_lg;
    logic [SPAN_W-1:0]   size;
    logic [SPAN_W-1:0]   blk_rows_m1;
    logic [SPAN_W-1:0]   next_base;
    logic [SPAN_W:0]     next_end;
    logic [HINT_W-1:0]   hint_adj;
    logic [CW-1:0]       cpu_idx;
    logic [SLOTS-1:0]    row_res;
    logic [SLOTS-1:0]    row_used;
    logic [SLOTS-1:0]    vec_bit;
    logic [SLOT_W-1:0]   eval_offset;
    logic                pic_hit;
    t_row_eval           row_eval;

    function automatic logic [AW-1:0] row_addr(input logic [CW-1:0] cpu,
                                               input logic [RW-1:0] row);
        logic [CW+RW-1:0] full;
        full = {cpu, row};
        return full[AW-1:0];
    endfunction

    // Memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_marks[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_marks[mem_raddr];
        end
    end

    // Row search logic.
    assign eval_offset = (r_state == S_ONE && r_first) ? r_hint[SLOT_W-1:0] : '0;

    ivalloc_row_eval #(
        .VECTORS      (VECTORS),
        .FIRST_VECTOR (FIRST_VECTOR),
        .RW           (RW)
    ) u_row_eval (
        .i_row    (r_row),
        .i_marks  (r_rdata),
        .i_offset (eval_offset),
        .i_grp_lg (r_lg[1:0]),
        .o_eval   (row_eval)
    );

    // Block size is the count rounded up to a power of two.
    always_comb begin
        count_lg = '0;
        for (int i = 0; i < SPAN_W; i++) begin
            if ((SPAN_W'(1) << i) < {1'b0, r_count}) begin
                count_lg = LG_W'(i + 1);
            end
        end
    end

    assign size        = SPAN_W'(1) << r_lg;
    assign blk_rows_m1 = (size >> SLOT_W) - SPAN_W'(1);
    assign next_base   = r_base + size;
    assign next_end    = {1'b0, next_base} + {1'b0, size};
    assign hint_adj    = (int'(r_hint) < FIRST_VECTOR) ?
                         r_hint + HINT_W'(FIRST_VECTOR) : r_hint;
    assign cpu_idx     = CW'(r_cpu);
    assign row_res     = r_rdata[SLOTS-1:0];
    assign row_used    = r_rdata[2*SLOTS-1:SLOTS];
    assign vec_bit     = SLOTS'(1) << r_vec[SLOT_W-1:0];
    assign pic_hit     = r_first && r_pic &&
                         (int'(r_hint) >= PIC_LOW_VECTOR) && (int'(r_hint) <= PIC_HIGH_VECTOR) &&
                         !row_used[r_hint[SLOT_W-1:0]];

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_result_vector = r_out_vec;
    assign o_status        = r_out_st;

    // Next state, memory access and result selection.
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_op        = r_op;
        n_cpu       = r_cpu;
        n_hint      = r_hint;
        n_count     = r_count;
        n_vec       = r_vec;
        n_lg        = r_lg;
        n_row       = r_row;
        n_k         = r_k;
        n_first     = r_first;
        n_base      = r_base;
        n_res_vec   = r_res_vec;
        n_res_st    = r_res_st;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_vec   = r_out_vec;
        n_out_st    = r_out_st;
        mem_we      = 1'b0;
        mem_waddr   = row_addr(cpu_idx, r_row);
        mem_wdata   = r_rdata;
        mem_re      = 1'b0;
        mem_raddr   = row_addr(cpu_idx, r_row);

        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_operation;
                    n_cpu   = i_cpu;
                    n_hint  = i_hint;
                    n_count = i_count;
                    n_vec   = i_vector;
                    n_state = S_DECODE;
                end
            end

            S_DECODE: begin
                n_res_vec = '0;
                n_res_st  = ST_OK;
                n_lg      = count_lg;
                n_first   = 1'b1;
                n_k       = '0;
                if (int'(r_cpu) >= CPUS || r_op > OP_DETACH) begin
                    n_res_st = ST_INVALID;
                    n_state  = S_FINISH;
                end else if (r_op == OP_RESERVE_ONE) begin
                    if (int'(r_hint) >= VECTORS) begin
                        n_res_st = ST_INVALID;
                        n_state  = S_FINISH;
                    end else begin
                        n_hint    = hint_adj;
                        n_row     = RW'(hint_adj >> SLOT_W);
                        mem_re    = 1'b1;
                        mem_raddr = row_addr(cpu_idx, RW'(hint_adj >> SLOT_W));
                        n_state   = S_ONE;
                    end
                end else if (r_op == OP_RESERVE_BLOCK) begin
                    if (count_lg <= LG_W'(SLOT_W)) begin
                        n_row     = RW'(FIRST_ROW);
                        mem_re    = 1'b1;
                        mem_raddr = row_addr(cpu_idx, RW'(FIRST_ROW));
                        n_state   = S_SMALL;
                    end else begin
                        // Size and base follow from the new exponent, not r_lg.
                        n_state = S_BIG;
                        n_base  = ((SPAN_W'(1) << count_lg) > SPAN_W'(FIRST_VECTOR)) ?
                                  (SPAN_W'(1) << count_lg) : SPAN_W'(FIRST_VECTOR);
                        if (({1'b0, n_base} + ((SPAN_W + 1)'(1) << count_lg)) >
                            (SPAN_W + 1)'(VECTORS)) begin
                            n_res_st = ST_NOSPACE;
                            n_state  = S_FINISH;
                        end else begin
                            n_row     = RW'(n_base >> SLOT_W);
                            mem_re    = 1'b1;
                            mem_raddr = row_addr(cpu_idx, RW'(n_base >> SLOT_W));
                        end
                    end
                end else if (int'(r_vec) >= FIRST_VECTOR && int'(r_vec) < VECTORS) begin
                    n_row     = RW'(r_vec >> SLOT_W);
                    mem_re    = 1'b1;
                    mem_raddr = row_addr(cpu_idx, RW'(r_vec >> SLOT_W));
                    n_state   = S_MODIFY;
                end else begin
                    n_state = S_FINISH;
                end
            end

            // Read, modify and write back the mark row of one vector.
            S_MODIFY: begin
                mem_we = 1'b1;
                case (r_op)
                    OP_FREE:   mem_wdata = {row_used & ~vec_bit, row_res & ~vec_bit};
                    OP_ATTACH: mem_wdata = {row_used | vec_bit, row_res};
                    default:   mem_wdata = {row_used & ~vec_bit, row_res};
                endcase
                n_state = S_FINISH;
            end

            // Single vector: legacy slot first, then upward row by row.
            S_ONE: begin
                if (pic_hit) begin
                    mem_we    = 1'b1;
                    mem_wdata = {row_used, row_res | (SLOTS'(1) << r_hint[SLOT_W-1:0])};
                    n_res_vec = r_hint[VEC_W-1:0];
                    n_state   = S_FINISH;
                end else if (row_eval.one_hit) begin
                    mem_we    = 1'b1;
                    mem_wdata = {row_used, row_res | (SLOTS'(1) << row_eval.one_idx)};
                    n_res_vec = VEC_W'({r_row, row_eval.one_idx});
                    n_state   = S_FINISH;
                end else if (r_row == RW'(ROWS - 1)) begin
                    n_res_st = ST_NOSPACE;
                    n_state  = S_FINISH;
                end else begin
                    n_first   = 1'b0;
                    n_row     = r_row + RW'(1);
                    mem_re    = 1'b1;
                    mem_raddr = row_addr(cpu_idx, r_row + RW'(1));
                end
            end

            // Blocks of up to eight vectors fit inside one row.
            S_SMALL: begin
                if (row_eval.grp_hit) begin
                    mem_we    = 1'b1;
                    mem_wdata = {row_used, row_res | row_eval.grp_mask};
                    n_res_vec = VEC_W'({r_row, row_eval.grp_idx});
                    n_state   = S_FINISH;
                end else if (r_row == RW'(ROWS - 1)) begin
                    n_res_st = ST_NOSPACE;
                    n_state  = S_FINISH;
                end else begin
                    n_row     = r_row + RW'(1);
                    mem_re    = 1'b1;
                    mem_raddr = row_addr(cpu_idx, r_row + RW'(1));
                end
            end

            // Larger blocks: every row of a candidate must be entirely free.
            S_BIG: begin
                if (row_eval.row_free) begin
                    if (r_k == blk_rows_m1[RW-1:0]) begin
                        n_row   = RW'(r_base >> SLOT_W);
                        n_k     = '0;
                        n_state = S_MARK;
                    end else begin
                        n_k       = r_k + RW'(1);
                        n_row     = r_row + RW'(1);
                        mem_re    = 1'b1;
                        mem_raddr = row_addr(cpu_idx, r_row + RW'(1));
                    end
                end else if (next_end > (SPAN_W + 1)'(VECTORS)) begin
                    n_res_st = ST_NOSPACE;
                    n_state  = S_FINISH;
                end else begin
                    n_base    = next_base;
                    n_k       = '0;
                    n_row     = RW'(next_base >> SLOT_W);
                    mem_re    = 1'b1;
                    mem_raddr = row_addr(cpu_idx, RW'(next_base >> SLOT_W));
                end
            end

            // Reserve every slot of the granted block, one row per cycle.
            S_MARK: begin
                mem_we    = 1'b1;
                mem_wdata = {{SLOTS{1'b0}}, {SLOTS{1'b1}}};
                if (r_k == blk_rows_m1[RW-1:0]) begin
                    n_res_vec = r_base[VEC_W-1:0];
                    n_state   = S_FINISH;
                end else begin
                    n_k   = r_k + RW'(1);
                    n_row = r_row + RW'(1);
                end
            end

            // Hand the result to the output register once it is free.
            S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_vec   = (r_res_st == ST_OK) ? r_res_vec : '0;
                    n_out_st    = r_res_st;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_pic       <= PIC_MODE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_pic <= i_cfg_wdata;
            end
        end
    end

    // Request and result payload registers.
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_cpu     <= n_cpu;
        r_hint    <= n_hint;
        r_count   <= n_count;
        r_vec     <= n_vec;
        r_lg      <= n_lg;
        r_row     <= n_row;
        r_k       <= n_k;
        r_first   <= n_first;
        r_base    <= n_base;
        r_res_vec <= n_res_vec;
        r_res_st  <= n_res_st;
        r_out_vec <= n_out_vec;
        r_out_st  <= n_out_st;
    end

endmodule

>>> hw/rtl/ivalloc_row_eval.sv
module ivalloc_row_eval
    import ivalloc_pkg::*;
#(
    parameter int VECTORS      = IVA_VECTORS,
    parameter int FIRST_VECTOR = IVA_FIRST_VECTOR,
    parameter int RW           = 5
) (
    input  logic [RW-1:0]      i_row,
    input  logic [2*SLOTS-1:0] i_marks,
    input  logic [SLOT_W-1:0]  i_offset,
    input  logic [1:0]         i_grp_lg,
    output t_row_eval          o_eval
);

    logic [SLOTS-1:0]     reserved;
    logic [SLOTS-1:0]     used;
    logic [SLOTS-1:0]     free_mask;
    logic [SLOTS-1:0]     one_cand;
    logic [SLOTS-1:0]     grp_cand;
    logic [SLOTS-1:0]     grp_smask;
    logic [SLOT_W:0]      grp_size;
    logic [RW+SLOT_W-1:0] slot_num;

    assign reserved = i_marks[SLOTS-1:0];
    assign used     = i_marks[2*SLOTS-1:SLOTS];

    // A slot is free when neither mark is set and it lies among the device vectors.
    always_comb begin
        free_mask = '0;
        slot_num  = '0;
        for (int j = 0; j < SLOTS; j++) begin
            slot_num     = {i_row, SLOT_W'(j)};
            free_mask[j] = !reserved[j] && !used[j] &&
                           (int'(slot_num) >= FIRST_VECTOR) && (int'(slot_num) < VECTORS);
        end
    end

    // Single slot search starts at the offset within the row.
    assign one_cand = free_mask & (SLOTS'({SLOTS{1'b1}}) << i_offset);

    // Aligned group search for groups of one to eight slots.
    assign grp_size  = (SLOT_W + 1)'(1) << i_grp_lg;
    assign grp_smask = (SLOTS'(1) << grp_size) - SLOTS'(1);

    always_comb begin
        grp_cand = '0;
        for (int j = 0; j < SLOTS; j++) begin
            grp_cand[j] = ((SLOT_W'(j) & SLOT_W'(grp_size - (SLOT_W + 1)'(1))) == '0) &&
                          (((free_mask >> j) & grp_smask) == grp_smask);
        end
    end

    // Lowest candidate wins in both searches.
    always_comb begin
        o_eval          = '0;
        o_eval.one_hit  = |one_cand;
        o_eval.grp_hit  = |grp_cand;
        o_eval.row_free = &free_mask;
        for (int j = SLOTS - 1; j >= 0; j--) begin
            if (one_cand[j]) begin
                o_eval.one_idx = SLOT_W'(j);
            end
            if (grp_cand[j]) begin
                o_eval.grp_idx = SLOT_W'(j);
            end
        end
        o_eval.grp_mask = grp_smask << o_eval.grp_idx;
    end

endmodule

>>> tb/tb_interrupt_vector_allocator.sv
`timescale 1ns / 100ps

module tb_interrupt_vector_allocator;
    import ivalloc_pkg::*;

    localparam int VECTORS       = IVA_VECTORS;
    localparam int FIRST_VECTOR  = IVA_FIRST_VECTOR;
    localparam int CPUS          = IVA_CPUS;
    localparam int DEVICE_SPAN   = VECTORS - FIRST_VECTOR;
    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 8;
    localparam int IDLE_PCT      = 38;
    localparam int SETTLE_CYCLES = 80;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 215;
    localparam int STEADY_PHASE  = 2;
    localparam int REPORT_MAX    = 10;
    localparam int DIRECTED_ROWS = 25;

    // Operation codes the block rejects.
    localparam logic [OP_W-1:0] OP_UNDEF_LO = OP_DETACH + 3'd1;
    localparam logic [OP_W-1:0] OP_UNDEF_HI = '1;

    typedef struct packed {
        logic [VEC_W-1:0] vec;
        t_status          st;
    } t_grant;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [CPU_W-1:0]   cpu;
        logic [HINT_W-1:0]  hint;
        logic [COUNT_W-1:0] count;
        logic [VEC_W-1:0]   vector;
        logic               typed;
        t_grant             want;
    } t_request_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic               i_cfg_wdata;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [OP_W-1:0]    i_operation;
    logic [CPU_W-1:0]   i_cpu;
    logic [HINT_W-1:0]  i_hint;
    logic [COUNT_W-1:0] i_count;
    logic [VEC_W-1:0]   i_vector;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [VEC_W-1:0]   o_result_vector;
    logic [ST_W-1:0]    o_status;

    // Shadow copy of the vector tables and of the PIC mode register.
    logic   slot_reserved [CPUS][VECTORS];
    logic   slot_used     [CPUS][VECTORS];
    logic   pic_mode_model;
    t_grant pending_grants [$];
    int     mismatch_count;
    int     cycle_count;
    logic   steady_mode;

    // Directed requests; rows with a typed result are checked against it directly.
    t_request_row directed_rows [DIRECTED_ROWS] = '{
        '{OP_RESERVE_ONE,   2'd0, 9'd0,   9'd0,   8'd0,   1'b1, '{8'd32,  ST_OK}},
        '{OP_RESERVE_ONE,   2'd0, 9'd32,  9'd0,   8'd0,   1'b1, '{8'd32,  ST_OK}},
        '{OP_RESERVE_ONE,   2'd0, 9'd256, 9'd0,   8'd0,   1'b1, '{8'd0,   ST_INVALID}},
        '{OP_RESERVE_ONE,   2'd0, 9'd511, 9'd0,   8'd0,   1'b1, '{8'd0,   ST_INVALID}},
        '{OP_RESERVE_ONE,   2'd1, 9'd255, 9'd0,   8'd0,   1'b1, '{8'd255, ST_OK}},
        '{OP_RESERVE_ONE,   2'd1, 9'd255, 9'd0,   8'd0,   1'b1, '{8'd0,   ST_NOSPACE}},
        '{OP_RESERVE_BLOCK, 2'd2, 9'd0,   9'd0,   8'd0,   1'b1, '{8'd32,  ST_OK}},
        '{OP_RESERVE_BLOCK, 2'd2, 9'd0,   9'd256, 8'd0,   1'b1, '{8'd0,   ST_NOSPACE}},
        '{OP_RESERVE_BLOCK, 2'd2, 9'd0,   9'd128, 8'd0,   1'b1, '{8'd128, ST_OK}},
        '{OP_RESERVE_BLOCK, 2'd2, 9'd0,   9'd3,   8'd0,   1'b0, '{8'd0,   ST_OK}},
        '{OP_RESERVE_BLOCK, 2'd3, 9'd0,   9'd129, 8'd0,   1'b1, '{8'd0,   ST_NOSPACE}},
        '{OP_RESERVE_BLOCK, 2'd3, 9'd0,   9'd511, 8'd0,   1'b1, '{8'd0,   ST_NOSPACE}},
        '{OP_ATTACH,        2'd0, 9'd0,   9'd0,   8'd33,  1'b1, '{8'd0,   ST_OK}},
        '{OP_RESERVE_ONE,   2'd0, 9'd33,  9'd0,   8'd0,   1'b0, '{8'd0,   ST_OK}},
        '{OP_ATTACH,        2'd0, 9'd0,   9'd0,   8'd32,  1'b1, '{8'd0,   ST_OK}},
        '{OP_RESERVE_ONE,   2'd0, 9'd0,   9'd0,   8'd0,   1'b0, '{8'd0,   ST_OK}},
        '{OP_DETACH,        2'd0, 9'd0,   9'd0,   8'd33,  1'b1, '{8'd0,   ST_OK}},
        '{OP_FREE,          2'd0, 9'd0,   9'd0,   8'd32,  1'b1, '{8'd0,   ST_OK}},
        '{OP_ATTACH,        2'd0, 9'd0,   9'd0,   8'd0,   1'b1, '{8'd0,   ST_OK}},
        '{OP_FREE,          2'd0, 9'd0,   9'd0,   8'd31,  1'b1, '{8'd0,   ST_OK}},
        '{OP_DETACH,        2'd1, 9'd0,   9'd0,   8'd255, 1'b1, '{8'd0,   ST_OK}},
        '{OP_FREE,          2'd1, 9'd0,   9'd0,   8'd255, 1'b1, '{8'd0,   ST_OK}},
        '{OP_UNDEF_LO,      2'd3, 9'd511, 9'd511, 8'd255, 1'b1, '{8'd0,   ST_INVALID}},
        '{OP_UNDEF_HI,      2'd0, 9'd0,   9'd0,   8'd0,   1'b1, '{8'd0,   ST_INVALID}},
        '{OP_RESERVE_ONE,   2'd3, 9'd31,  9'd0,   8'd0,   1'b0, '{8'd0,   ST_OK}}
    };

    interrupt_vector_allocator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_cpu          (i_cpu),
        .i_hint         (i_hint),
        .i_count        (i_count),
        .i_vector       (i_vector),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_vector(o_result_vector),
        .o_status       (o_status)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Computes the grant of one request and applies it to the shadow tables.
    function automatic t_grant predict_allocation(
        input logic [OP_W-1:0]    op,
        input logic [CPU_W-1:0]   cpu,
        input logic [HINT_W-1:0]  hint,
        input logic [COUNT_W-1:0] count,
        input logic [VEC_W-1:0]   vector
    );
        t_grant g;
        int     c;
        int     start;
        int     size;
        int     base;
        logic   found;
        logic   clear_run;
        g.vec = '0;
        g.st  = ST_OK;
        c     = int'(cpu);
        found = 1'b0;
        if (c >= CPUS || op > OP_DETACH) begin
            g.st = ST_INVALID;
        end else if (op == OP_RESERVE_ONE) begin
            start = int'(hint);
            if (start >= VECTORS) begin
                g.st = ST_INVALID;
            end else begin
                if (start < FIRST_VECTOR) begin
                    start += FIRST_VECTOR;
                end
                // Inside the legacy window the hint only has to be unused.
                if (pic_mode_model && start >= PIC_LOW_VECTOR && start <= PIC_HIGH_VECTOR
                        && !slot_used[c][start]) begin
                    found = 1'b1;
                    g.vec = VEC_W'(start);
                end
                for (int v = start; v < VECTORS && !found; v++) begin
                    if (!slot_used[c][v] && !slot_reserved[c][v]) begin
                        found = 1'b1;
                        g.vec = VEC_W'(v);
                    end
                end
                if (found) begin
                    slot_reserved[c][g.vec] = 1'b1;
                end else begin
                    g.st = ST_NOSPACE;
                end
            end
        end else if (op == OP_RESERVE_BLOCK) begin
            size = 1;
            while (size < int'(count)) begin
                size <<= 1;
            end
            // Walk the naturally aligned runs from the first device vector up.
            base = (FIRST_VECTOR + size - 1) / size * size;
            while (base + size <= VECTORS && !found) begin
                clear_run = 1'b1;
                for (int i = 0; i < size; i++) begin
                    if (slot_used[c][base + i] || slot_reserved[c][base + i]) begin
                        clear_run = 1'b0;
                    end
                end
                if (clear_run) begin
                    found = 1'b1;
                end else begin
                    base += size;
                end
            end
            if (found) begin
                for (int i = 0; i < size; i++) begin
                    slot_reserved[c][base + i] = 1'b1;
                end
                g.vec = VEC_W'(base);
            end else begin
                g.st = ST_NOSPACE;
            end
        end else if (int'(vector) >= FIRST_VECTOR && int'(vector) < VECTORS) begin
            case (op)
                OP_FREE: begin
                    slot_reserved[c][vector] = 1'b0;
                    slot_used[c][vector]     = 1'b0;
                end
                OP_ATTACH: begin
                    slot_used[c][vector] = 1'b1;
                end
                default: begin
                    slot_used[c][vector] = 1'b0;
                end
            endcase
        end
        return g;
    endfunction

    // Drives one request, waits for its acceptance and records the grant it is owed.
    task automatic send_request(input t_request_row row);
        t_grant predicted;
        @(negedge i_clk);
        while (!steady_mode && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_operation <= row.op;
        i_cpu       <= row.cpu;
        i_hint      <= row.hint;
        i_count     <= row.count;
        i_vector    <= row.vector;
        i_in_valid  <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (o_in_stall !== 1'b0);
        predicted = predict_allocation(row.op, row.cpu, row.hint, row.count, row.vector);
        pending_grants.push_back(row.typed ? row.want : predicted);
    endtask

    // Holds requests back until every grant has come out and the block has settled.
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_grants.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the PIC mode register while the block is idle.
    task automatic write_pic_mode(input logic value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we       <= 1'b0;
        pic_mode_model = value;
    endtask

    // The result side stalls at random except during the steady stretch.
    always @(negedge i_clk) begin
        i_out_stall <= !steady_mode && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Each delivered result is compared with the oldest grant still owed.
    always @(posedge i_clk) begin : result_check
        t_grant want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (pending_grants.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX) begin
                    $display("unexpected result: vector %0d status %0d",
                             o_result_vector, o_status);
                end
            end else begin
                want = pending_grants.pop_front();
                if (o_result_vector !== want.vec || o_status !== want.st) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX) begin
                        $display("result mismatch: expected vector %0d status %0d, %s %0d %s %0d",
                                 want.vec, want.st, "got vector", o_result_vector,
                                 "status", o_status);
                    end
                end
            end
        end
    end

    // Watchdog on the total run length.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Reset, directed requests, then random phases under alternating PIC modes.
    initial begin : stimulus
        t_request_row row;
        int           pick;
        int           start;
        int           v;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = 1'b0;
        i_in_valid     = 1'b0;
        i_operation    = '0;
        i_cpu          = '0;
        i_hint         = '0;
        i_count        = '0;
        i_vector       = '0;
        steady_mode    = 1'b0;
        mismatch_count = 0;
        pic_mode_model = PIC_MODE_RESET;
        for (int c = 0; c < CPUS; c++) begin
            for (int s = 0; s < VECTORS; s++) begin
                slot_reserved[c][s] = 1'b0;
                slot_used[c][s]     = 1'b0;
            end
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The directed part runs with the PIC mode left at its reset value.
        foreach (directed_rows[i]) begin
            send_request(directed_rows[i]);
        end
        drain_results();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            write_pic_mode(phase % 2 == 1);
            steady_mode = (phase == STEADY_PHASE);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Every request field starts fully random; the one the operation uses may then be shaped.
                row.op     = OP_W'($urandom);
                row.cpu    = CPU_W'($urandom);
                row.hint   = HINT_W'($urandom);
                row.count  = COUNT_W'($urandom);
                row.vector = VEC_W'($urandom);
                row.typed  = 1'b0;
                row.want   = '0;
                pick = $urandom_range(0, 99);
                if (pick < 28) begin
                    row.op = OP_RESERVE_ONE;
                    pick = $urandom_range(0, 9);
                    if (pick < 4) begin
                        row.hint = HINT_W'($urandom_range(0, PIC_HIGH_VECTOR));
                    end else if (pick < 8) begin
                        row.hint = HINT_W'($urandom_range(FIRST_VECTOR, VECTORS - 1));
                    end else if (pick < 9) begin
                        row.hint = HINT_W'($urandom_range(VECTORS, (1 << HINT_W) - 1));
                    end
                end else if (pick < 42) begin
                    row.op = OP_RESERVE_BLOCK;
                    pick = $urandom_range(0, 99);
                    if (pick < 70) begin
                        row.count = COUNT_W'($urandom_range(0, 8));
                    end else if (pick < 90) begin
                        row.count = COUNT_W'($urandom_range(9, 64));
                    end else if (pick < 97) begin
                        row.count = COUNT_W'($urandom_range(65, VECTORS));
                    end
                end else if (pick < 94) begin
                    row.op = (pick < 72) ? OP_FREE : (pick < 84) ? OP_ATTACH : OP_DETACH;
                    pick = $urandom_range(0, 9);
                    if (pick < 7) begin
                        // Aim at a vector this CPU holds, so tables keep turning over.
                        start = $urandom_range(FIRST_VECTOR, VECTORS - 1);
                        row.vector = VEC_W'(start);
                        for (int i = 0; i < DEVICE_SPAN; i++) begin
                            v = FIRST_VECTOR + (start - FIRST_VECTOR + i) % DEVICE_SPAN;
                            if (slot_reserved[row.cpu][v] || slot_used[row.cpu][v]) begin
                                row.vector = VEC_W'(v);
                                break;
                            end
                        end
                    end else if (pick < 9) begin
                        row.vector = VEC_W'($urandom_range(FIRST_VECTOR, VECTORS - 1));
                    end
                end else begin
                    row.op = OP_W'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
                end
                send_request(row);
                // Now and then the sender waits for every outstanding result.
                if ($urandom_range(0, 199) == 0) begin
                    drain_results();
                end
            end
            drain_results();
        end

        if (mismatch_count == 0 && pending_grants.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
